// ===== rtl/pgc_pkg.sv =====
// Shared types, constants and register codes of the palette gradient color block.
`timescale 1ns / 1ps
`default_nettype none

package pgc_pkg;

	// Field widths
	localparam int W_IDX   = 8;
	localparam int W_COLOR = 24;
	localparam int W_CHAN  = 8;
	localparam int N_CHAN  = W_COLOR / W_CHAN;

	// Weight scale: weights run 0..SCALE
	localparam int SCALE    = 1000;
	localparam int W_WEIGHT = 10;

	// Divider: quotient bits below SCALE, retired a few per stage
	localparam int DIV_QBITS  = W_WEIGHT;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;
	localparam int W_DIVIDEND = W_IDX + DIV_QBITS;

	// Blend sum and divide by SCALE through a reciprocal
	localparam int W_BLEND     = W_CHAN + W_WEIGHT;
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + SCALE - 1) / SCALE;
	localparam int W_RECIP     = 19;
	localparam int W_PROD      = W_BLEND + W_RECIP;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_FIRST   = 3'd1,
		REG_LAST    = 3'd2,
		REG_COLOR_A = 3'd3,
		REG_COLOR_B = 3'd4
	} pgc_reg_t;

	localparam int W_REG_IDX = 3;

	// Gradient modes
	typedef enum logic {
		MODE_LINEAR   = 1'b0,
		MODE_CENTERED = 1'b1
	} pgc_mode_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		pgc_mode_t           mode;
		logic [W_IDX-1:0]    first;
		logic [W_IDX-1:0]    last;
		logic [W_COLOR-1:0]  color_a;
		logic [W_COLOR-1:0]  color_b;
	} pgc_cfg_t;

	// Side data that travels with an item
	typedef struct packed {
		logic               in_range;
		logic [W_IDX-1:0]   entry;
		logic [W_COLOR-1:0] x;
		logic [W_COLOR-1:0] y;
	} pgc_side_t;

	// Request into the divider
	typedef struct packed {
		pgc_side_t             side;
		logic                  sat;
		logic [W_DIVIDEND-1:0] dividend;
		logic [W_IDX-1:0]      divisor;
	} pgc_div_req_t;

	// One divider stage
	typedef struct packed {
		pgc_side_t             side;
		logic                  sat;
		logic [W_DIVIDEND-1:0] dividend;
		logic [W_IDX-1:0]      divisor;
		logic [W_IDX-1:0]      rem;
		logic [DIV_QBITS-1:0]  quo;
	} pgc_div_stg_t;

	// Request into the blender
	typedef struct packed {
		pgc_side_t           side;
		logic [W_WEIGHT-1:0] weight;
	} pgc_mix_req_t;

	// Result item
	typedef struct packed {
		logic              in_range;
		logic [W_IDX-1:0]  entry;
		logic [W_CHAN-1:0] red;
		logic [W_CHAN-1:0] green;
		logic [W_CHAN-1:0] blue;
	} pgc_color_t;

endpackage

`default_nettype wire

// ===== rtl/pgc_ifs.sv =====
// Valid/ready channel interfaces for palette indexes and gradient colors.
`timescale 1ns / 1ps
`default_nettype none

interface pgc_index_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;

	modport source (output valid, output index, input ready);
	modport sink (input valid, input index, output ready);
endinterface

interface pgc_color_if;
	logic       valid;
	logic       ready;
	logic       in_range;
	logic [7:0] entry;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output in_range, output entry, output red,
		output green, output blue, input ready);
	modport sink (input valid, input in_range, input entry, input red,
		input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/pgc_front.sv =====
// Front stages: range check, weight numerator and divisor, scaled dividend.
`timescale 1ns / 1ps
`default_nettype none

module pgc_front
	import pgc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pgc_cfg_t         cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [W_IDX-1:0] index,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pgc_div_req_t          out_req
);

	logic [W_IDX:0]   mid_sum;
	logic [W_IDX-1:0] mid;
	logic [W_IDX-1:0] gap;
	logic [W_IDX-1:0] num_d;
	logic [W_IDX-1:0] div_d;
	logic             in_range_d;

	logic             vld_s1;
	pgc_side_t        side_s1;
	logic [W_IDX-1:0] num_s1;
	logic [W_IDX-1:0] div_s1;
	logic             sat_s1;
	logic             rdy_s1;

	logic             vld_s2;
	pgc_div_req_t     req_s2;
	logic             rdy_s2;

	// Numerator and divisor for the selected mode
	always_comb begin
		mid_sum    = {1'b0, cfg.first} + {1'b0, cfg.last};
		mid        = mid_sum[W_IDX:1];
		gap        = (mid >= index) ? (mid - index) : (index - mid);
		in_range_d = (index >= cfg.first) && (index <= cfg.last);
		if (cfg.mode == MODE_CENTERED) begin
			num_d = gap;
			div_d = mid - cfg.first;
		end else begin
			num_d = cfg.last - index;
			div_d = cfg.last - cfg.first;
		end
	end

	// Stall chain
	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 1 and stage 2 valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= in_valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
		end
	end

	// Stage 1: capture operands; a numerator at or above the divisor saturates
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			side_s1.in_range <= in_range_d;
			side_s1.entry    <= index;
			side_s1.x        <= (cfg.mode == MODE_CENTERED) ? cfg.color_b : cfg.color_a;
			side_s1.y        <= (cfg.mode == MODE_CENTERED) ? cfg.color_a : cfg.color_b;
			num_s1           <= num_d;
			div_s1           <= div_d;
			sat_s1           <= (num_d >= div_d);
		end
	end

	// Stage 2: scale the numerator by SCALE
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			req_s2.side     <= side_s1;
			req_s2.sat      <= sat_s1;
			req_s2.dividend <= W_DIVIDEND'(num_s1) * W_DIVIDEND'(SCALE);
			req_s2.divisor  <= div_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_req   = req_s2;

endmodule

`default_nettype wire

// ===== rtl/pgc_div.sv =====
// Pipelined restoring divider that forms the gradient weight.
`timescale 1ns / 1ps
`default_nettype none

module pgc_div
	import pgc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire pgc_div_req_t in_req,
	output logic              out_valid,
	input  wire logic         out_ready,
	output pgc_mix_req_t      out_req
);

	localparam int W_QIDX = $clog2(DIV_QBITS);

	pgc_div_stg_t                  stg_s [DIV_STAGES];
	pgc_div_stg_t                  stg_d [DIV_STAGES];
	logic         [DIV_STAGES-1:0] vld_s;
	logic         [DIV_STAGES-1:0] vin;
	logic         [DIV_STAGES-1:0] rdy;
	pgc_div_stg_t                  init;

	// Retire DIV_STEP quotient bits, highest first
	function automatic pgc_div_stg_t div_step(pgc_div_stg_t st, logic [W_QIDX-1:0] hi_bit);
		pgc_div_stg_t         r;
		logic [DIV_QBITS-1:0] low;
		logic [W_IDX:0]       trial;
		logic [W_QIDX-1:0]    kb;
		r   = st;
		low = st.dividend[DIV_QBITS-1:0];
		for (int j = 0; j < DIV_STEP; j++) begin
			kb    = hi_bit - W_QIDX'(j);
			trial = {r.rem, low[kb]};
			if (trial >= {1'b0, r.divisor}) begin
				r.rem     = W_IDX'(trial - {1'b0, r.divisor});
				r.quo[kb] = 1'b1;
			end else begin
				r.rem = trial[W_IDX-1:0];
			end
		end
		return r;
	endfunction

	// Seed the partial remainder with the dividend's top bits
	always_comb begin
		init.side     = in_req.side;
		init.sat      = in_req.sat;
		init.dividend = in_req.dividend;
		init.divisor  = in_req.divisor;
		init.rem      = in_req.dividend[W_DIVIDEND-1:DIV_QBITS];
		init.quo      = '0;
	end

	// Next stage contents and the stall chain
	always_comb begin
		for (int g = 0; g < DIV_STAGES; g++) begin
			if (g == 0) begin
				stg_d[g] = div_step(init, W_QIDX'(DIV_QBITS - 1 - DIV_STEP * g));
				vin[g]   = in_valid;
			end else begin
				stg_d[g] = div_step(stg_s[g-1], W_QIDX'(DIV_QBITS - 1 - DIV_STEP * g));
				vin[g]   = vld_s[g-1];
			end
		end
		for (int g = DIV_STAGES - 1; g >= 0; g--) begin
			if (g == DIV_STAGES - 1)
				rdy[g] = !vld_s[g] || out_ready;
			else
				rdy[g] = !vld_s[g] || rdy[g+1];
		end
	end

	assign in_ready = rdy[0];

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int g = 0; g < DIV_STAGES; g++)
				if (rdy[g])
					vld_s[g] <= vin[g];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		for (int g = 0; g < DIV_STAGES; g++)
			if (rdy[g] && vin[g])
				stg_s[g] <= stg_d[g];
	end

	// Saturated weights go out at full scale
	assign out_valid      = vld_s[DIV_STAGES-1];
	assign out_req.side   = stg_s[DIV_STAGES-1].side;
	assign out_req.weight = stg_s[DIV_STAGES-1].sat ? W_WEIGHT'(SCALE)
		: stg_s[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// ===== rtl/pgc_mix.sv =====
// Channel blender: weighted sum, divide by scale, output register.
`timescale 1ns / 1ps
`default_nettype none

module pgc_mix
	import pgc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire pgc_mix_req_t in_req,
	output logic              out_valid,
	input  wire logic         out_ready,
	output pgc_color_t        out_color
);

	logic [W_BLEND-1:0]  blend_d [N_CHAN];
	logic [W_WEIGHT-1:0] inv_weight;

	logic                vld_s1;
	logic                in_range_s1;
	logic [W_IDX-1:0]    entry_s1;
	logic [W_BLEND-1:0]  blend_s1 [N_CHAN];

	logic                vld_s2;
	logic                in_range_s2;
	logic [W_IDX-1:0]    entry_s2;
	logic [W_PROD-1:0]   prod_s2 [N_CHAN];

	logic                vld_q;
	pgc_color_t          color_q;

	logic                rdy_q;
	logic                rdy_s2;
	logic                rdy_s1;

	// Weighted sum per channel
	always_comb begin
		inv_weight = W_WEIGHT'(SCALE) - in_req.weight;
		for (int c = 0; c < N_CHAN; c++)
			blend_d[c] = W_BLEND'(in_req.weight) * W_BLEND'(in_req.side.x[c*W_CHAN +: W_CHAN])
				+ W_BLEND'(inv_weight) * W_BLEND'(in_req.side.y[c*W_CHAN +: W_CHAN]);
	end

	// Stall chain
	assign rdy_q    = !vld_q || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_q;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= in_valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
			if (rdy_q)
				vld_q <= vld_s2;
		end
	end

	// Stage 1: hold the weighted sums
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			in_range_s1 <= in_req.side.in_range;
			entry_s1    <= in_req.side.entry;
			for (int c = 0; c < N_CHAN; c++)
				blend_s1[c] <= blend_d[c];
		end
	end

	// Stage 2: multiply by the reciprocal of the scale
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			in_range_s2 <= in_range_s1;
			entry_s2    <= entry_s1;
			for (int c = 0; c < N_CHAN; c++)
				prod_s2[c] <= W_PROD'(blend_s1[c]) * W_PROD'(RECIP);
		end
	end

	// Output register: drop the fraction, zero the colors out of range
	always_ff @(posedge clk) begin
		if (rdy_q && vld_s2) begin
			color_q.in_range <= in_range_s2;
			color_q.entry    <= entry_s2;
			color_q.red      <= in_range_s2 ? prod_s2[0][RECIP_SHIFT +: W_CHAN] : '0;
			color_q.green    <= in_range_s2 ? prod_s2[1][RECIP_SHIFT +: W_CHAN] : '0;
			color_q.blue     <= in_range_s2 ? prod_s2[2][RECIP_SHIFT +: W_CHAN] : '0;
		end
	end

	assign out_valid = vld_q;
	assign out_color = color_q;

endmodule

`default_nettype wire

// ===== rtl/palette_gradient_color.sv =====
// Path: front stages, then divider stages, then blender and output register.
// Throughput: one index per cycle while results are taken; every stage has its own
// valid bit and stalls only while the stage after it is full and stalled.
// Weight: five-stage restoring divider, two quotient bits per stage.
// Reset: arst_n clears all valid bits and returns the configuration registers
// to linear mode, range 0..255, color A white, color B black.
`timescale 1ns / 1ps
`default_nettype none

module palette_gradient_color
	import pgc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [W_REG_IDX-1:0] cfg_index,
	input  wire logic [W_COLOR-1:0]   cfg_data,
	pgc_index_if.sink                 index_ch,
	pgc_color_if.source               color_ch
);

	pgc_mode_t          mode_q;
	logic [W_IDX-1:0]   first_q;
	logic [W_IDX-1:0]   last_q;
	logic [W_COLOR-1:0] color_a_q;
	logic [W_COLOR-1:0] color_b_q;
	pgc_cfg_t           cfg;

	logic               fr_valid;
	logic               fr_ready;
	pgc_div_req_t       fr_req;
	logic               dv_valid;
	logic               dv_ready;
	pgc_mix_req_t       dv_req;
	pgc_color_t         color;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LINEAR;
			first_q   <= '0;
			last_q    <= '1;
			color_a_q <= '1;
			color_b_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:    mode_q    <= pgc_mode_t'(cfg_data[0]);
				REG_FIRST:   first_q   <= cfg_data[W_IDX-1:0];
				REG_LAST:    last_q    <= cfg_data[W_IDX-1:0];
				REG_COLOR_A: color_a_q <= cfg_data;
				REG_COLOR_B: color_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.first   = first_q;
	assign cfg.last    = last_q;
	assign cfg.color_a = color_a_q;
	assign cfg.color_b = color_b_q;

	pgc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (index_ch.valid),
		.in_ready  (index_ch.ready),
		.index     (index_ch.index),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_req   (fr_req)
	);

	pgc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_req    (fr_req),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_req   (dv_req)
	);

	pgc_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.in_req    (dv_req),
		.out_valid (color_ch.valid),
		.out_ready (color_ch.ready),
		.out_color (color)
	);

	assign color_ch.in_range = color.in_range;
	assign color_ch.entry    = color.entry;
	assign color_ch.red      = color.red;
	assign color_ch.green    = color.green;
	assign color_ch.blue     = color.blue;

`ifndef SYNTHESIS
	// An empty output register leaves the whole pipeline open for a transfer
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!color_ch.valid |-> index_ch.ready)
		else $error("input stalled with an empty output register");

	// The divider never hands on a weight above full scale
	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid |-> (dv_req.weight <= W_WEIGHT'(SCALE)))
		else $error("gradient weight above full scale");

	// Out-of-range results carry black
	a_out_of_range_black: assert property (@(posedge clk) disable iff (!arst_n)
		(color_ch.valid && !color_ch.in_range) |->
		(color_ch.red == '0 && color_ch.green == '0 && color_ch.blue == '0))
		else $error("out-of-range result with nonzero color");

	// A result that waits keeps waiting until it is taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(color_ch.valid && !color_ch.ready) |=> color_ch.valid)
		else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire
